>>> design/sjf_pkg.sv
// shared types and constants of the shortest-job-first scheduler
package sjf_pkg;

    localparam int unsigned ID_W   = 7;
    localparam int unsigned ARR_W  = 16;
    localparam int unsigned BUR_W  = 16;
    localparam int unsigned OUT_W  = 22;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic             valid;
        logic             done;
        logic [ID_W-1:0]  id;
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
    } job_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic            shift;
        logic            clr;
        logic            mark;
        logic [ID_W-1:0] mark_id;
    } cell_ctl_t;

    // running best picks of one scan pass
    typedef struct packed {
        logic have_ready;
        logic have_idle;
        job_t ready_job;
        job_t idle_job;
    } pick_t;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

endpackage

>>> design/sjf_if.sv
// valid/ready channel interfaces for job words and result words
interface sjf_in_if;
    logic                       valid;
    logic                       ready;
    logic [sjf_pkg::ARR_W-1:0]  arrival_time;
    logic [sjf_pkg::BUR_W-1:0]  burst_time;
    logic                       last_item;

    modport source (output valid, arrival_time, burst_time, last_item, input ready);
    modport sink   (input valid, arrival_time, burst_time, last_item, output ready);
endinterface

interface sjf_out_if;
    logic                       valid;
    logic                       ready;
    logic [sjf_pkg::ID_W-1:0]   job_id;
    logic [sjf_pkg::ARR_W-1:0]  job_arrival;
    logic [sjf_pkg::BUR_W-1:0]  job_burst;
    logic [sjf_pkg::OUT_W-1:0]  completion_time;
    logic [sjf_pkg::OUT_W-1:0]  turnaround_time;
    logic [sjf_pkg::OUT_W-1:0]  waiting_time;
    logic                       last_result;

    modport source (output valid, job_id, job_arrival, job_burst, completion_time,
                    turnaround_time, waiting_time, last_result, input ready);
    modport sink   (input valid, job_id, job_arrival, job_burst, completion_time,
                    turnaround_time, waiting_time, last_result, output ready);
endinterface

>>> design/sjf_cell.sv
// one job slot of the rotating job chain
module sjf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sjf_pkg::cell_ctl_t ctl,
    input  sjf_pkg::job_t      d,
    output sjf_pkg::job_t      q
);
    import sjf_pkg::*;

    logic             valid_reg, valid_next;
    logic             done_reg, done_next;
    logic [ID_W-1:0]  id_reg;
    logic [ARR_W-1:0] arr_reg;
    logic [BUR_W-1:0] bur_reg;

    always_comb
    begin
        valid_next = valid_reg;
        done_next  = done_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
            done_next  = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = d.valid;
            done_next  = d.done;
        end
        else if (ctl.mark && valid_reg && (id_reg == ctl.mark_id))
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift && !ctl.clr)
        begin
            id_reg  <= d.id;
            arr_reg <= d.arrival;
            bur_reg <= d.burst;
        end
    end

    assign q = '{valid: valid_reg, done: done_reg, id: id_reg,
                 arrival: arr_reg, burst: bur_reg};

endmodule

>>> design/sjf_pick.sv
// compare unit at the chain head: keeps the best ready and best idle job of a pass
module sjf_pick (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       first,
    input  sjf_pkg::job_t              head,
    input  logic [sjf_pkg::OUT_W-1:0]  cur_time,
    output sjf_pkg::pick_t             best
);
    import sjf_pkg::*;

    localparam int unsigned KEY_W = BUR_W + ARR_W + ID_W;

    logic             have_r_reg, have_r_next, have_i_reg, have_i_next;
    job_t             job_r_reg, job_i_reg;
    logic             live, arrived, take_r, take_i;
    logic [KEY_W-1:0] rkey_h, rkey_b, ikey_h, ikey_b;

    always_comb
    begin
        live    = head.valid && !head.done;
        arrived = ({{(OUT_W-ARR_W){1'b0}}, head.arrival} <= cur_time);
        // ready order: burst, then arrival, then id
        rkey_h  = {head.burst, head.arrival, head.id};
        rkey_b  = {job_r_reg.burst, job_r_reg.arrival, job_r_reg.id};
        // idle order: arrival, then burst, then id
        ikey_h  = {head.arrival, head.burst, head.id};
        ikey_b  = {job_i_reg.arrival, job_i_reg.burst, job_i_reg.id};
        take_r  = live && arrived && (first || !have_r_reg || (rkey_h < rkey_b));
        take_i  = live && (first || !have_i_reg || (ikey_h < ikey_b));
        have_r_next = (first ? 1'b0 : have_r_reg) | (live && arrived);
        have_i_next = (first ? 1'b0 : have_i_reg) | live;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_r_reg <= 1'b0;
            have_i_reg <= 1'b0;
        end
        else if (en)
        begin
            have_r_reg <= have_r_next;
            have_i_reg <= have_i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && take_r)
        begin
            job_r_reg <= head;
        end
        if (en && take_i)
        begin
            job_i_reg <= head;
        end
    end

    assign best = '{have_ready: have_r_reg, have_idle: have_i_reg,
                    ready_job: job_r_reg, idle_job: job_i_reg};

endmodule

>>> design/sjf_nonpreemptive_scheduler.sv
// top level of the non-preemptive shortest-job-first scheduler
//
//  channel   dir  word                                       last marker
//  job_in    in   arrival_time, burst_time                   last_item starts scheduling
//  res_out   out  job_id, job_arrival, job_burst, times      last_result on final job
//
// loading takes one cycle per job word; jobs beyond MAX_JOBS are dropped
// each scheduled job takes a full rotation of the chain and then a calc step,
// set by the single compare unit watching the chain head
// a clear step ends a batch; no job word is taken while scheduling runs
// reset (rst_n, async, active low) empties the chain and returns to loading
// a stalled result word holds the calc step until the output register frees
module sjf_nonpreemptive_scheduler #(
    parameter int unsigned MAX_JOBS   = 32,
    parameter int unsigned TIME_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    sjf_in_if.sink            job_in,
    sjf_out_if.source         res_out
);
    import sjf_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int unsigned SCAN_W = $clog2(MAX_JOBS);
    // arrival and burst keep only TIME_WIDTH low bits
    localparam logic [ARR_W-1:0] TMASK = (TIME_WIDTH >= ARR_W) ? {ARR_W{1'b1}}
                                         : ARR_W'((64'd1 << TIME_WIDTH) - 64'd1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [OUT_W-1:0]  cur_reg, cur_next;

    // chain of job cells; cell 0 is the head seen by the compare unit
    job_t      cell_q [MAX_JOBS];
    job_t      cell_d [MAX_JOBS];
    job_t      new_job;
    cell_ctl_t ctl;
    pick_t     best;
    logic      load_fire, can_store, scan_en, scan_first;

    // result path
    logic             ov_reg, ov_next;
    job_t             sel;
    logic             have_any, res_last, res_fire;
    logic [OUT_W-1:0] base, ct, tat, wt, arr_ext, bur_ext;
    logic [OUT_W:0]   sum;
    logic [ID_W-1:0]  o_id_reg;
    logic [ARR_W-1:0] o_arr_reg;
    logic [BUR_W-1:0] o_bur_reg;
    logic [OUT_W-1:0] o_ct_reg, o_tat_reg, o_wt_reg;
    logic             o_last_reg;

    assign job_in.ready = (state_reg == ST_LOAD);
    assign load_fire    = job_in.valid && job_in.ready;
    assign can_store    = (count_reg < CNT_W'(MAX_JOBS));

    assign new_job = '{valid: 1'b1, done: 1'b0,
                       id: ID_W'(count_reg) + ID_W'(1),
                       arrival: job_in.arrival_time & TMASK,
                       burst: job_in.burst_time & TMASK};

    // load shifts a new job in at the tail, scanning rotates the ring
    generate
        for (genvar i = 0; i < MAX_JOBS; i++)
        begin : g_chain
            if (i == MAX_JOBS - 1)
            begin : g_tail
                assign cell_d[i] = (state_reg == ST_LOAD) ? new_job : cell_q[0];
            end
            else
            begin : g_body
                assign cell_d[i] = cell_q[i+1];
            end
            sjf_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .d     (cell_d[i]),
                .q     (cell_q[i])
            );
        end
    endgenerate

    assign scan_en    = (state_reg == ST_SCAN);
    assign scan_first = (scan_reg == '0);

    sjf_pick u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (scan_en),
        .first    (scan_first),
        .head     (cell_q[0]),
        .cur_time (cur_reg),
        .best     (best)
    );

    // schedule step: ready pick wins, otherwise the clock jumps to the idle pick
    always_comb
    begin
        have_any = best.have_ready || best.have_idle;
        sel      = best.have_ready ? best.ready_job : best.idle_job;
        arr_ext  = {{(OUT_W-ARR_W){1'b0}}, sel.arrival};
        bur_ext  = {{(OUT_W-BUR_W){1'b0}}, sel.burst};
        base     = (!best.have_ready && (arr_ext > cur_reg)) ? arr_ext : cur_reg;
        sum      = {1'b0, base} + {1'b0, bur_ext};
        ct       = sum[OUT_W] ? OUT_MAX : sum[OUT_W-1:0];
        tat      = (ct >= arr_ext) ? (ct - arr_ext) : '0;
        wt       = (tat >= bur_ext) ? (tat - bur_ext) : '0;
        res_last = ((emit_reg + CNT_W'(1)) == count_reg);
        res_fire = (state_reg == ST_CALC) && have_any && (!ov_reg || res_out.ready);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        emit_next   = emit_reg;
        scan_next   = scan_reg;
        cur_next    = cur_reg;
        ov_next     = ov_reg && !res_out.ready;
        ctl         = '{shift: 1'b0, clr: 1'b0, mark: 1'b0, mark_id: sel.id};
        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    if (can_store)
                    begin
                        ctl.shift  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (job_in.last_item)
                    begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                        cur_next   = '0;
                        emit_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.shift = 1'b1;
                if (scan_reg == SCAN_W'(MAX_JOBS - 1))
                begin
                    scan_next  = '0;
                    state_next = ST_CALC;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            ST_CALC:
            begin
                if (!have_any)
                begin
                    state_next = ST_CLEAR;
                end
                else if (res_fire)
                begin
                    ov_next    = 1'b1;
                    ctl.mark   = 1'b1;
                    cur_next   = ct;
                    emit_next  = emit_reg + CNT_W'(1);
                    state_next = res_last ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_CLEAR:
            begin
                ctl.clr    = 1'b1;
                count_next = '0;
                cur_next   = '0;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            emit_reg  <= '0;
            scan_reg  <= '0;
            cur_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            emit_reg  <= emit_next;
            scan_reg  <= scan_next;
            cur_reg   <= cur_next;
            ov_reg    <= ov_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            o_id_reg   <= sel.id;
            o_arr_reg  <= sel.arrival;
            o_bur_reg  <= sel.burst;
            o_ct_reg   <= ct;
            o_tat_reg  <= tat;
            o_wt_reg   <= wt;
            o_last_reg <= res_last;
        end
    end

    assign res_out.valid           = ov_reg;
    assign res_out.job_id          = o_id_reg;
    assign res_out.job_arrival     = o_arr_reg;
    assign res_out.job_burst       = o_bur_reg;
    assign res_out.completion_time = o_ct_reg;
    assign res_out.turnaround_time = o_tat_reg;
    assign res_out.waiting_time    = o_wt_reg;
    assign res_out.last_result     = o_last_reg;

endmodule

>>> design/sjf_checker.sv
// port-level checks of the scheduler, bound to the top level
module sjf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [sjf_pkg::ARR_W-1:0]  out_arr,
    input logic [sjf_pkg::BUR_W-1:0]  out_bur,
    input logic [sjf_pkg::OUT_W-1:0]  out_ct,
    input logic [sjf_pkg::OUT_W-1:0]  out_tat,
    input logic [sjf_pkg::OUT_W-1:0]  out_wt
);
    import sjf_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ct))
        else $error("result word changed while stalled");

    // scheduling starts after the last job word and blocks loading
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("job word taken right after last item");

    // turnaround is completion minus arrival when positive
    a_tat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_tat != '0) |-> out_ct == out_tat + OUT_W'(out_arr))
        else $error("turnaround mismatch");

    // waiting is turnaround minus burst when positive
    a_wt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_wt != '0) |-> out_tat == out_wt + OUT_W'(out_bur))
        else $error("waiting time mismatch");

endmodule

bind sjf_nonpreemptive_scheduler sjf_checker u_sjf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (job_in.valid),
    .in_ready  (job_in.ready),
    .in_last   (job_in.last_item),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_arr   (res_out.job_arrival),
    .out_bur   (res_out.job_burst),
    .out_ct    (res_out.completion_time),
    .out_tat   (res_out.turnaround_time),
    .out_wt    (res_out.waiting_time)
);
